// File: rtl/s16a_pkg.sv
// Shared types and constants for the signed 16-bit to decimal ASCII converter.
// No dependencies.
`default_nettype none

package s16a_pkg;

   localparam int VALUE_W    = 16;
   localparam int DIGIT_W    = 4;
   localparam int NUM_DIGITS = 5;
   localparam int BCD_W      = DIGIT_W * NUM_DIGITS;
   localparam int CHAR_W     = 6;
   localparam int STEP_CNT_W = 4;  // one step per magnitude bit
   localparam int DIG_CNT_W  = 3;  // holds 1 to NUM_DIGITS

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

   // Converted value handed from the BCD unit to the character emitter
   typedef struct packed {
      logic             valid;
      logic             neg;
      logic [BCD_W-1:0] digits;
   } bcd_result_type;

   typedef enum logic [1:0] {
      EMIT_IDLE,
      EMIT_SKIP,
      EMIT_SIGN,
      EMIT_DIGIT
   } emit_state_type;

endpackage

`default_nettype wire

// File: rtl/s16a_bcd.sv
// Bit-serial binary to BCD converter (shift and add-3), one magnitude bit per cycle.
// Depends on s16a_pkg.
`default_nettype none

module s16a_bcd
   import s16a_pkg::*;
(
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   input  wire                      start_neg,
   input  wire [VALUE_W-1:0]        start_mag,
   output logic                     busy,
   output bcd_result_type           result
);

   logic [VALUE_W-1:0]    mag_ff,  mag_in;
   logic [BCD_W-1:0]      bcd_ff,  bcd_in;
   logic [STEP_CNT_W-1:0] cnt_ff,  cnt_in;
   logic                  run_ff,  run_in;
   logic                  done_ff, done_in;
   logic                  neg_ff,  neg_in;
   logic [BCD_W-1:0]      adjusted;

   // Digits of 5 or more get 3 added before the shift
   always_comb begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd_ff[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
            adjusted[d*DIGIT_W +: DIGIT_W] = bcd_ff[d*DIGIT_W +: DIGIT_W] + 4'd3;
         end else begin
            adjusted[d*DIGIT_W +: DIGIT_W] = bcd_ff[d*DIGIT_W +: DIGIT_W];
         end
      end
   end

   always_comb begin
      mag_in  = mag_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      if (start) begin
         mag_in = start_mag;
         bcd_in = '0;
         cnt_in = {STEP_CNT_W{1'b1}};
         run_in = 1'b1;
         neg_in = start_neg;
      end else if (run_ff) begin
         bcd_in = {adjusted[BCD_W-2:0], mag_ff[VALUE_W-1]};
         mag_in = {mag_ff[VALUE_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign busy          = run_ff | done_ff;
   assign result.valid  = done_ff;
   assign result.neg    = neg_ff;
   assign result.digits = bcd_ff;

endmodule

`default_nettype wire

// File: rtl/s16a_emit.sv
// Character emitter: drops leading zeros a digit per cycle, then sends sign and digits
// through an output register. Depends on s16a_pkg.
`default_nettype none

module s16a_emit
   import s16a_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   input  bcd_result_type      load,
   output logic                busy,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic [CHAR_W-1:0]   rsp_char_code,
   output logic                rsp_last_char
);

   emit_state_type       state_ff, state_in;
   logic [BCD_W-1:0]     dig_ff,   dig_in;
   logic [DIG_CNT_W-1:0] cnt_ff,   cnt_in;
   logic                 neg_ff,   neg_in;
   logic                 out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]    out_char_ff,  out_char_in;
   logic                 out_last_ff,  out_last_in;
   logic [DIGIT_W-1:0]   top_digit;
   logic                 slot_free;
   logic                 one_left;

   assign top_digit = dig_ff[BCD_W-1 -: DIGIT_W];
   assign slot_free = !out_valid_ff || !rsp_stall;
   assign one_left  = (cnt_ff == DIG_CNT_W'(1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         EMIT_IDLE: begin
            if (load.valid) state_in = EMIT_SKIP;
         end
         EMIT_SKIP: begin
            if (top_digit != '0 || one_left) state_in = neg_ff ? EMIT_SIGN : EMIT_DIGIT;
         end
         EMIT_SIGN: begin
            if (slot_free) state_in = EMIT_DIGIT;
         end
         EMIT_DIGIT: begin
            if (slot_free && one_left) state_in = EMIT_IDLE;
         end
         default: state_in = EMIT_IDLE;
      endcase
   end

   always_comb begin
      dig_in       = dig_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         EMIT_IDLE: begin
            if (load.valid) begin
               dig_in = load.digits;
               neg_in = load.neg;
               cnt_in = DIG_CNT_W'(NUM_DIGITS);
            end
         end
         EMIT_SKIP: begin
            if (top_digit == '0 && !one_left) begin
               dig_in = {dig_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
               cnt_in = cnt_ff - 1'b1;
            end
         end
         EMIT_SIGN: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_char_in  = CHAR_MINUS;
               out_last_in  = 1'b0;
            end
         end
         EMIT_DIGIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_char_in  = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
               out_last_in  = one_left;
               dig_in       = {dig_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
               cnt_in       = cnt_ff - 1'b1;
            end
         end
         default: begin
            out_valid_in = out_valid_ff && rsp_stall;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= EMIT_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      dig_ff      <= dig_in;
      cnt_ff      <= cnt_in;
      neg_ff      <= neg_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign busy          = (state_ff != EMIT_IDLE);
   assign rsp_valid     = out_valid_ff;
   assign rsp_char_code = out_char_ff;
   assign rsp_last_char = out_last_ff;

endmodule

`default_nettype wire

// File: rtl/signed_int16_to_decimal_ascii.sv
// Flow: an accepted value goes through the bit-serial BCD conversion and is handed over to
// the emitter, which drops leading zeros a digit per cycle and then sends the sign and the
// digits, held back by every result stall. Values are not overlapped: req_stall is high until
// the last character of the previous value has entered the output register.
// Reset: synchronous, active high; clears the control state and the output valid flag.
// Depends on s16a_pkg, s16a_bcd and s16a_emit.
`default_nettype none

module signed_int16_to_decimal_ascii
   import s16a_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire  signed [15:0]   req_value,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic [5:0]           rsp_char_code,
   output logic                 rsp_last_char
);

   logic               accept;
   logic               value_neg;
   logic [VALUE_W-1:0] value_mag;
   logic               conv_busy;
   logic               emit_busy;
   bcd_result_type     conv_result;

   assign req_stall = conv_busy | emit_busy;
   assign accept    = req_valid && !req_stall;

   // -32768 negates to 16'h8000, which is the right unsigned magnitude
   assign value_neg = req_value[VALUE_W-1];
   assign value_mag = value_neg ? (~req_value + 1'b1) : req_value;

   s16a_bcd u_bcd (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .start_neg (value_neg),
      .start_mag (value_mag),
      .busy      (conv_busy),
      .result    (conv_result)
   );

   s16a_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .load          (conv_result),
      .busy          (emit_busy),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

endmodule

`default_nettype wire
